/* sv/argument_count_scanner_defines.svh */
// Assertion macros for the argument count scanner.
// Each use expects signals named clock and reset in the enclosing module.
`ifndef ARGUMENT_COUNT_SCANNER_DEFINES_SVH
`define ARGUMENT_COUNT_SCANNER_DEFINES_SVH

`ifndef SYNTH

`define ACS_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("acs assertion failed");

`define ACS_ASSERT_NEVER(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("acs assertion failed");

`else

`define ACS_ASSERT(name, prop)

`define ACS_ASSERT_NEVER(name, expr)

`endif

`endif

/* sv/acs_pkg.sv */
package acs_pkg;

   localparam int MaxArgs = 63;
   localparam int CommaW  = $clog2(MaxArgs + 1);

   localparam logic [7:0] CharNul    = 8'h00;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharDquote = 8'h22;
   localparam logic [7:0] CharSquote = 8'h27;
   localparam logic [7:0] CharOpen   = 8'h28;
   localparam logic [7:0] CharClose  = 8'h29;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] CharColon  = 8'h3A;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerO = 8'h6F;
   localparam logic [7:0] CharLowerT = 8'h74;
   localparam logic [7:0] CaseOffset = 8'h20;

   localparam logic [6:0] CountMax = 7'd127;

   typedef enum logic [1:0] {
      StopColon   = 2'd0,
      StopBracket = 2'd1,
      StopEnd     = 2'd2
   } stop_type;

   typedef struct packed {
      logic [7:0]        depth;
      logic              dquote;
      logic              squote;
      logic [CommaW-1:0] comma;
      logic              content;
   } scan_type;

   typedef struct packed {
      scan_type nxt;
      logic     stop;
      stop_type why;
      logic     skip;
   } judge_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       start_of_text;
      logic       start_neg;
      logic       end_of_text;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [6:0] arg_count;
      stop_type   why;
   } result_type;

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= CharUpperA && c <= CharUpperZ) ? c + CaseOffset : c;
   endfunction

   function automatic logic [CommaW-1:0] add_comma(logic [CommaW-1:0] n);
      return (n < CommaW'(MaxArgs)) ? n + CommaW'(1) : n;
   endfunction

   function automatic logic [6:0] count_of(scan_type s);
      logic [8:0] n;
      n = 9'(s.comma) + 9'd1;
      if (s.comma != '0) begin
         return (n > 9'(CountMax)) ? CountMax : n[6:0];
      end
      return {6'd0, s.content};
   endfunction

   // judge one character c with the three characters after it in w0..w2
   function automatic judge_type judge(scan_type s, logic [7:0] c, logic look_ok,
                                       logic [7:0] w0, logic [7:0] w1,
                                       logic [7:0] w2);
      judge_type r;
      r.nxt  = s;
      r.stop = 1'b0;
      r.why  = StopEnd;
      r.skip = 1'b0;
      if (!s.dquote && !s.squote) begin
         if (s.depth == 8'd0 && c == CharClose) begin
            r.stop = 1'b1;
            r.why  = StopBracket;
         end else if (look_ok && c == CharSpace && to_lower(w0) == CharLowerT &&
                      to_lower(w1) == CharLowerO && w2 == CharSpace) begin
            r.skip = 1'b1;
            if (s.depth == 8'd0) begin
               r.nxt.comma = add_comma(s.comma);
            end
         end else begin
            case (c)
               CharOpen: begin
                  r.nxt.depth = s.depth + 8'd1;
               end
               CharClose: begin
                  r.nxt.depth = s.depth - 8'd1;
               end
               CharColon: begin
                  r.stop = 1'b1;
                  r.why  = StopColon;
               end
               CharComma: begin
                  if (s.depth == 8'd0) begin
                     r.nxt.comma = add_comma(s.comma);
                  end
               end
               CharSpace, CharTab: begin
               end
               default: begin
                  r.nxt.content = 1'b1;
               end
            endcase
         end
      end
      if (!r.stop && !r.skip) begin
         if (c == CharDquote && !s.squote) begin
            r.nxt.dquote = !s.dquote;
         end
         if (c == CharSquote && !s.dquote) begin
            r.nxt.squote = !s.squote;
         end
      end
      return r;
   endfunction

endpackage

/* sv/acs_if.sv */
interface acs_req_if;
   logic              valid;
   logic              ready;
   logic [7:0]        char_code;
   logic              start_of_text;
   logic signed [0:0] start_depth;
   logic              end_of_text;

   modport source (output valid, char_code, start_of_text, start_depth, end_of_text,
                   input ready);
   modport sink (input valid, char_code, start_of_text, start_depth, end_of_text,
                 output ready);
endinterface

interface acs_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] arg_count;
   logic [1:0] stop_reason;

   modport source (output valid, arg_count, stop_reason, input ready);
   modport sink (input valid, arg_count, stop_reason, output ready);
endinterface

/* sv/argument_count_scanner.sv */
// channel | dir | fields                                          | handshake
// req     | in  | char_code, start_of_text, start_depth, end_of_text | valid/ready
// rsp     | out | arg_count, stop_reason                          | valid/ready
//
// One transaction per cycle sustained while rsp is not stalled; a character passes an input
// stage register and its result, if any, is registered into the rsp output register.
// The scan state update for one character, with up to three held characters
// drained at end of text, is combinational from the input stage register.
// A stalled rsp holds the stage; req stays ready while the stage can move.
// After reset the scanner ignores characters until a start_of_text.
`include "argument_count_scanner_defines.svh"

module argument_count_scanner import acs_pkg::*; (
   input logic       clock,
   input logic       reset,
   acs_req_if.sink   req,
   acs_rsp_if.source rsp
);

   logic       stage_valid_ff, stage_valid_in;
   item_type   stage_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] arg_count_ff;
   stop_type   stop_reason_ff;
   logic       advance;
   result_type result;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !stage_valid_ff || advance;

   assign stage_valid_in = (req.valid && req.ready) || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance ? result.valid : (rsp_valid_ff && !rsp.ready);

   acs_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         stage_item_ff.char_code     <= req.char_code;
         stage_item_ff.start_of_text <= req.start_of_text;
         stage_item_ff.start_neg     <= req.start_depth[0];
         stage_item_ff.end_of_text   <= req.end_of_text;
      end
      if (advance && result.valid) begin
         arg_count_ff   <= result.arg_count;
         stop_reason_ff <= result.why;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.arg_count   = arg_count_ff;
   assign rsp.stop_reason = stop_reason_ff;

   `ACS_ASSERT(a_stall_blocks, rsp_valid_ff && !rsp.ready && stage_valid_ff |-> !req.ready)
   `ACS_ASSERT(a_accept_fills, req.valid && req.ready |=> stage_valid_ff)
   `ACS_ASSERT(a_rsp_from_stage, $rose(rsp_valid_ff) |-> $past(advance))

endmodule

/* sv/acs_scan.sv */
`include "argument_count_scanner_defines.svh"

module acs_scan import acs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output result_type result
);

   scan_type   scan_ff, scan_in;
   logic       finished_ff, finished_in;
   logic [1:0] fill_ff, fill_in;
   logic [7:0] look_ff [3];
   logic [7:0] look_in [3];

   always_comb begin
      scan_type   s;
      logic       fin;
      logic [1:0] fill;
      logic [7:0] la [3];
      judge_type  j;
      logic       ended;
      logic       stop;
      stop_type   why;

      s     = scan_ff;
      fin   = finished_ff;
      fill  = fill_ff;
      la    = look_ff;
      j     = '0;
      stop  = 1'b0;
      why   = StopEnd;
      ended = 1'b0;
      result = '0;

      if (item.start_of_text) begin
         s       = '0;
         s.depth = item.start_neg ? 8'hFF : 8'h00;
         fin     = 1'b0;
         fill    = 2'd0;
      end

      if (!fin) begin
         ended = item.end_of_text || item.char_code == CharNul;
         if (item.char_code != CharNul) begin
            if (fill != 2'd3) begin
               la[fill] = item.char_code;
               fill     = fill + 2'd1;
            end else begin
               j = judge(s, la[0], 1'b1, la[1], la[2], item.char_code);
               if (j.stop) begin
                  stop = 1'b1;
                  why  = j.why;
               end else if (j.skip) begin
                  s    = j.nxt;
                  fill = 2'd0;
               end else begin
                  s     = j.nxt;
                  la[0] = la[1];
                  la[1] = la[2];
                  la[2] = item.char_code;
               end
            end
         end

         // drain the held characters in order
         for (int k = 0; k < 3; k++) begin
            if (ended && !stop && 2'(k) < fill) begin
               j = judge(s, la[k], 1'b0, CharNul, CharNul, CharNul);
               if (j.stop) begin
                  stop = 1'b1;
                  why  = j.why;
               end else begin
                  s = j.nxt;
               end
            end
         end

         if (stop || ended) begin
            result.valid     = 1'b1;
            result.arg_count = count_of(s);
            result.why       = why;
            fin              = 1'b1;
            fill             = 2'd0;
         end
      end

      scan_in     = s;
      finished_in = fin;
      fill_in     = fill;
      look_in     = la;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         finished_ff <= 1'b1;
         fill_ff     <= 2'd0;
      end else if (advance) begin
         scan_ff     <= scan_in;
         finished_ff <= finished_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         look_ff <= look_in;
      end
   end

   `ACS_ASSERT(a_idle_silent, advance && finished_ff && !item.start_of_text |-> !result.valid)
   `ACS_ASSERT_NEVER(a_comma_cap, scan_ff.comma > CommaW'(MaxArgs))
   `ACS_ASSERT(a_done_clears, advance && result.valid |=> finished_ff && fill_ff == 2'd0)

endmodule

/* dv/argument_count_scanner_tb.sv */
module argument_count_scanner_tb;
   import acs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {JudgeGo, JudgeSkip, JudgeStop} verdict_type;

   typedef struct {
      logic [6:0] count;
      stop_type   why;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset;

   acs_req_if req ();
   acs_rsp_if rsp ();

   argument_count_scanner dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted scan state
   logic [7:0] scan_depth;
   bit         scan_dq;
   bit         scan_sq;
   int         scan_commas;
   bit         scan_content;
   bit         scan_done;
   logic [7:0] held [3];
   int         held_n;

   scan_result_type expected_scans[$];
   logic [7:0]      text_buf[$];

   bit req_idling;
   bit rsp_idling;
   int errors;
   int texts_sent;
   int chars_sent;
   int scans_checked;
   int stops_seen [3];

   function automatic int draw_wait(bit on);
      return on ? $urandom_range(0, 17) : 0;
   endfunction

   function automatic void append_char(logic [7:0] c);
      text_buf = {text_buf, c};
   endfunction

   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= CharUpperA && c <= CharUpperZ) ? c + CaseOffset : c;
   endfunction

   function automatic void add_arg_comma();
      if (scan_commas < MaxArgs) begin
         scan_commas++;
      end
   endfunction

   function automatic void clear_scan();
      scan_depth   = 8'h00;
      scan_dq      = 1'b0;
      scan_sq      = 1'b0;
      scan_commas  = 0;
      scan_content = 1'b0;
      scan_done    = 1'b1;
      held_n       = 0;
      for (int i = 0; i < 3; i++) begin
         held[i] = 8'h00;
      end
   endfunction

   function automatic verdict_type judge_char(input logic [7:0] c, input logic [7:0] w0,
                                              input logic [7:0] w1, input logic [7:0] w2,
                                              input int wn, output stop_type why);
      why = StopEnd;
      if (!scan_dq && !scan_sq) begin
         if (scan_depth == 8'h00 && c == CharClose) begin
            why = StopBracket;
            return JudgeStop;
         end
         if (wn >= 3 && c == CharSpace && fold_case(w0) == CharLowerT &&
             fold_case(w1) == CharLowerO && w2 == CharSpace) begin
            if (scan_depth == 8'h00) begin
               add_arg_comma();
            end
            return JudgeSkip;
         end
         case (c)
            CharOpen: begin
               scan_depth = scan_depth + 8'h01;
            end
            CharClose: begin
               scan_depth = scan_depth - 8'h01;
            end
            CharColon: begin
               why = StopColon;
               return JudgeStop;
            end
            CharComma: begin
               if (scan_depth == 8'h00) begin
                  add_arg_comma();
               end
            end
            CharSpace, CharTab: begin
            end
            default: begin
               scan_content = 1'b1;
            end
         endcase
      end
      if (c == CharDquote && !scan_sq) begin
         scan_dq = !scan_dq;
      end
      if (c == CharSquote && !scan_dq) begin
         scan_sq = !scan_sq;
      end
      return JudgeGo;
   endfunction

   function automatic bit close_scan(input stop_type why, output scan_result_type res);
      int n;
      scan_done = 1'b1;
      held_n    = 0;
      if (scan_commas > 0) begin
         n = scan_commas + 1;
         res.count = (n > int'(CountMax)) ? CountMax : 7'(n);
      end else begin
         res.count = {6'd0, scan_content};
      end
      res.why = why;
      return 1'b1;
   endfunction

   function automatic bit predict_scan(input item_type it, output scan_result_type res);
      verdict_type r;
      stop_type    why;
      logic [7:0]  c;
      bit          end_flag;
      c        = it.char_code;
      end_flag = it.end_of_text;
      res.count = 7'd0;
      res.why   = StopEnd;
      if (it.start_of_text) begin
         clear_scan();
         scan_done  = 1'b0;
         scan_depth = it.start_neg ? 8'hFF : 8'h00;
      end
      if (scan_done) begin
         return 1'b0;
      end
      if (c == CharNul) begin
         end_flag = 1'b1;
      end else if (held_n < 3) begin
         held[held_n] = c;
         held_n++;
      end else begin
         r = judge_char(held[0], held[1], held[2], c, 3, why);
         if (r == JudgeStop) begin
            return close_scan(why, res);
         end
         if (r == JudgeSkip) begin
            held_n = 0;
         end else begin
            held[0] = held[1];
            held[1] = held[2];
            held[2] = c;
         end
      end
      if (!end_flag) begin
         return 1'b0;
      end
      while (held_n > 0) begin
         r = judge_char(held[0], held[1], held[2], CharNul, held_n - 1, why);
         if (r == JudgeStop) begin
            return close_scan(why, res);
         end
         held[0] = held[1];
         held[1] = held[2];
         held_n--;
      end
      return close_scan(StopEnd, res);
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      if (errors <= 40) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
   endtask

   task automatic send_char(logic [7:0] c, bit first, bit neg, bit last);
      int              gap;
      item_type        it;
      scan_result_type res;
      gap = draw_wait(req_idling);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      it.char_code     = c;
      it.start_of_text = first;
      it.start_neg     = neg;
      it.end_of_text   = last;
      req.valid         <= 1'b1;
      req.char_code     <= c;
      req.start_of_text <= first;
      req.start_depth   <= neg;
      req.end_of_text   <= last;
      do @(posedge clock); while (req.ready !== 1'b1);
      chars_sent++;
      if (predict_scan(it, res)) begin
         expected_scans = {expected_scans, res};
      end
   endtask

   task automatic send_text(bit neg, bit ended);
      texts_sent++;
      foreach (text_buf[i]) begin
         send_char(text_buf[i], i == 0, (i == 0) ? neg : 1'($urandom_range(0, 1)),
                   ended && i == text_buf.size() - 1);
      end
   endtask

   // check each result transaction against the oldest prediction
   initial begin
      int              stall;
      scan_result_type want;
      rsp.ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_wait(rsp_idling);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (rsp.valid !== 1'b1);
         scans_checked++;
         if (expected_scans.size() == 0) begin
            report_mismatch($sformatf("unexpected result count=%0d reason=%0d",
                                      rsp.arg_count, rsp.stop_reason));
         end else begin
            want = expected_scans.pop_front();
            if (want.why <= StopEnd) begin
               stops_seen[want.why]++;
            end
            if (rsp.arg_count !== want.count) begin
               report_mismatch($sformatf("arg_count %0d, expected %0d",
                                         rsp.arg_count, want.count));
            end
            if (rsp.stop_reason !== want.why) begin
               report_mismatch($sformatf("stop_reason %0d, expected %s",
                                         rsp.stop_reason, want.why.name()));
            end
         end
      end
   end

   task automatic test_idle_before_start();
      send_char("q", 1'b0, 1'b0, 1'b0);
      send_char(CharComma, 1'b0, 1'b1, 1'b1);
   endtask

   task automatic test_empty_texts();
      send_char(CharSpace, 1'b1, 1'b0, 1'b1);
      send_char(CharNul, 1'b1, 1'b1, 1'b1);
      send_char(8'hFF, 1'b1, 1'b0, 1'b1);
   endtask

   task automatic test_zero_byte();
      text_buf = '{"x", CharComma, CharNul};
      send_text(1'b0, 1'b0);
   endtask

   task automatic test_to_word();
      text_buf = '{"a", CharSpace, "T", "o", CharSpace, "b"};
      send_text(1'b0, 1'b1);
   endtask

   task automatic test_quotes();
      text_buf = '{CharDquote, CharComma, CharDquote, CharComma,
                   CharSquote, CharColon, CharSquote, "z"};
      send_text(1'b0, 1'b1);
   endtask

   task automatic test_colon_stop();
      text_buf = '{CharColon, "b", "c", "d", "e"};
      send_text(1'b0, 1'b1);
      send_char("f", 1'b0, 1'b0, 1'b1);
   endtask

   task automatic test_bracket_stop();
      text_buf = '{CharOpen, CharClose, "x", "y", "z"};
      send_text(1'b1, 1'b1);
   endtask

   task automatic test_depth_wrap();
      text_buf.delete();
      repeat (256) append_char(CharOpen);
      append_char(CharComma);
      append_char("x");
      send_text(1'b0, 1'b1);
   endtask

   task automatic test_comma_saturation();
      text_buf.delete();
      repeat (70) begin
         append_char(CharUpperA + 8'($urandom_range(0, 25)));
         append_char(CharComma);
      end
      append_char("z");
      send_text(1'b0, 1'b1);
   endtask

   function automatic logic [7:0] any_letter();
      return CharUpperA + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? CaseOffset : 8'h00);
   endfunction

   function automatic void push_to_word();
      append_char(CharSpace);
      append_char(CharLowerT - ($urandom_range(0, 1) ? CaseOffset : 8'h00));
      append_char(CharLowerO - ($urandom_range(0, 1) ? CaseOffset : 8'h00));
      append_char(CharSpace);
   endfunction

   function automatic void build_text();
      int         ntok;
      logic [7:0] q;
      text_buf.delete();
      ntok = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      repeat (ntok) begin
         case ($urandom_range(0, 15))
            0, 1, 2: append_char(any_letter());
            3, 4: append_char(CharComma);
            5, 6: push_to_word();
            7: append_char($urandom_range(0, 1) ? CharSpace : CharTab);
            8: begin
               append_char(CharOpen);
               append_char(any_letter());
               append_char(CharComma);
               push_to_word();
               append_char(CharClose);
            end
            9: begin
               q = $urandom_range(0, 1) ? CharDquote : CharSquote;
               append_char(q);
               repeat ($urandom_range(0, 3)) begin
                  case ($urandom_range(0, 4))
                     0: append_char(CharComma);
                     1: append_char(CharColon);
                     2: append_char(CharClose);
                     3: append_char((q == CharDquote) ? CharSquote : CharDquote);
                     default: push_to_word();
                  endcase
               end
               if ($urandom_range(0, 5) != 0) begin
                  append_char(q);
               end
            end
            10: append_char(CharOpen);
            11: append_char(CharClose);
            12: append_char(CharColon);
            13: append_char(8'($urandom_range(1, 255)));
            14: begin
               append_char(CharSpace);
               append_char(CharLowerT);
               if ($urandom_range(0, 1)) begin
                  append_char(CharSpace);
               end else begin
                  append_char(CharLowerO);
                  append_char(any_letter());
               end
            end
            default: append_char(8'h30 + 8'($urandom_range(0, 9)));
         endcase
      end
   endfunction

   task automatic test_random_texts();
      int  mode;
      bit  neg;
      while (chars_sent < 1100) begin
         req_idling = $urandom_range(0, 3) != 0;
         rsp_idling = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
         end
         build_text();
         mode = $urandom_range(0, 9);
         neg  = 1'($urandom_range(0, 1));
         if (mode == 0) begin
            append_char(CharNul);
         end
         send_text(neg, mode > 1);
      end
   endtask

   initial begin
      reset             = 1'b1;
      req.valid         = 1'b0;
      req.char_code     = 8'h00;
      req.start_of_text = 1'b0;
      req.start_depth   = 1'b0;
      req.end_of_text   = 1'b0;
      req_idling        = 1'b0;
      rsp_idling        = 1'b0;
      clear_scan();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_idle_before_start();
      test_empty_texts();
      test_zero_byte();
      rsp_idling = 1'b1;
      test_to_word();
      test_quotes();
      req_idling = 1'b1;
      test_colon_stop();
      test_bracket_stop();
      req_idling = 1'b0;
      test_depth_wrap();
      req_idling = 1'b1;
      test_comma_saturation();
      test_random_texts();

      req.valid <= 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("ran %0d texts over %0d accepted characters, %0d scan results checked",
               texts_sent, chars_sent, scans_checked);
      $display("stops by colon %0d, by bracket %0d, by end of text %0d, mismatches %0d",
               stops_seen[StopColon], stops_seen[StopBracket], stops_seen[StopEnd], errors);
      if (errors == 0) begin
         $display("argument_count_scanner_tb passed");
      end else begin
         $display("argument_count_scanner_tb failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: %0d results still pending", expected_scans.size());
      $display("argument_count_scanner_tb failed");
      $finish;
   end

endmodule
